>>> src/lci_pkg.sv
// Shared widths, types and codes for the line/circle intersection pipeline.
`default_nettype none
package lci_pkg;

  localparam int COORD_W     = 24;
  localparam int RAD_W       = COORD_W - 1;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int LEN_W       = PROD_W;
  localparam int R2_W        = 2 * RAD_W;
  localparam int MUL_HW      = 26;
  localparam int MUL_W       = 2 * MUL_HW;
  localparam int MULP_W      = 2 * MUL_W;
  localparam int MUL_LAT     = 3;
  localparam int DISC_W      = 2 * RAD_W + 2 * DIFF_W;
  localparam int ROOT_W      = DISC_W / 2;
  localparam int SQ_REM_W    = ROOT_W + 4;
  localparam int NUM_W       = PROD_W + DIFF_W + 1;
  localparam int QUO_W       = COORD_W + 2;
  localparam int FIN_W       = COORD_W + 5;
  localparam int NLANE       = 4;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

  // Square root cell: radicand bits still to shift in, partial root, remainder.
  typedef struct packed {
    logic [DISC_W-1:0]   rad;
    logic [ROOT_W-1:0]   root;
    logic [SQ_REM_W-1:0] rem;
  } sqrt_t;

  // Divider cell: divisor, partial remainder, dividend bits and quotient bits.
  typedef struct packed {
    logic [LEN_W-1:0] den;
    logic [LEN_W-1:0] rem;
    logic [QUO_W-1:0] nq;
  } div_t;

endpackage
`default_nettype wire

>>> src/lci_mul.sv
// Three-stage unsigned multiplier built from four half-width partial products.
`default_nettype none
module lci_mul import lci_pkg::*; (
  input  logic              clk_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [MULP_W-1:0] p_o
);

  logic [MUL_W-1:0]  p00_q, p01_q, p10_q, p11_q;
  logic [MUL_W:0]    mid_q;
  logic [MULP_W-1:0] outer_q;

  always_ff @(posedge clk_i) begin
    p00_q   <= MUL_W'(a_i[MUL_HW-1:0]) * MUL_W'(b_i[MUL_HW-1:0]);
    p01_q   <= MUL_W'(a_i[MUL_HW-1:0]) * MUL_W'(b_i[MUL_W-1:MUL_HW]);
    p10_q   <= MUL_W'(a_i[MUL_W-1:MUL_HW]) * MUL_W'(b_i[MUL_HW-1:0]);
    p11_q   <= MUL_W'(a_i[MUL_W-1:MUL_HW]) * MUL_W'(b_i[MUL_W-1:MUL_HW]);
    // outer products do not overlap: concatenate them
    mid_q   <= (MUL_W+1)'(p01_q) + (MUL_W+1)'(p10_q);
    outer_q <= {p11_q, p00_q};
    p_o     <= outer_q + (MULP_W'(mid_q) << MUL_HW);
  end

endmodule
`default_nettype wire

>>> src/lci_sqrt_cell.sv
// One root bit of the digit-by-digit integer square root.
`default_nettype none
module lci_sqrt_cell import lci_pkg::*; (
  input  logic  clk_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  logic [SQ_REM_W-1:0] rem_sh, trial;
  logic                ge;
  sqrt_t               cell_d;

  always_comb begin
    rem_sh = {cell_i.rem[SQ_REM_W-3:0], cell_i.rad[DISC_W-1 -: 2]};
    trial  = SQ_REM_W'({cell_i.root, 2'b01});
    ge     = rem_sh >= trial;
    cell_d.rad  = {cell_i.rad[DISC_W-3:0], 2'b00};
    cell_d.root = {cell_i.root[ROOT_W-2:0], ge};
    cell_d.rem  = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    cell_o <= cell_d;
  end

endmodule
`default_nettype wire

>>> src/lci_div_cell.sv
// One quotient bit of a restoring divider; dividend bits shift out as quotient bits shift in.
`default_nettype none
module lci_div_cell import lci_pkg::*; (
  input  logic clk_i,
  input  div_t cell_i,
  output div_t cell_o
);

  logic [LEN_W:0] rem2, den_x, diff;
  logic           ge;
  div_t           cell_d;

  always_comb begin
    rem2  = {cell_i.rem, cell_i.nq[QUO_W-1]};
    den_x = {1'b0, cell_i.den};
    ge    = rem2 >= den_x;
    diff  = rem2 - den_x;
    cell_d.den = cell_i.den;
    cell_d.rem = ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
    cell_d.nq  = {cell_i.nq[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    cell_o <= cell_d;
  end

endmodule
`default_nettype wire

>>> src/line_circle_intersection_top.sv
// Top level of the pipelined line/circle intersection block.
//
// Usage: drive the two line points, the circle centre and radius and raise
// start_i for one cycle per query. busy_o is always low, so an item is taken
// at every rising edge where start_i is high: one query per clock cycle,
// back to back, with up to 89 queries in flight.
//
// The result item appears on the result ports once the query has passed the
// whole pipe, for exactly one cycle, marked by valid_o. The receiver
// cannot stall the block; it must take each result in that cycle.
//
// The pipe is made of the row of 48 square-root cells (one root bit each, for
// the 96-bit discriminant), the row of 26 divider cells per output lane (one
// quotient bit each), two rows of 3-stage split multipliers and nine single
// stages of differences, products, sums, rounding and saturation.
//
// Reset clears every valid bit at once, so nothing is reported until a new
// query has passed the whole pipe. Data registers carry no reset.
`default_nettype none
module line_circle_intersection_top import lci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [COORD_W-1:0] line_start_x_i,
  input  logic [COORD_W-1:0] line_start_y_i,
  input  logic [COORD_W-1:0] line_end_x_i,
  input  logic [COORD_W-1:0] line_end_y_i,
  input  logic [COORD_W-1:0] center_x_i,
  input  logic [COORD_W-1:0] center_y_i,
  input  logic [RAD_W-1:0]   radius_i,
  output logic               valid_o,
  output logic [1:0]         hit_count_o,
  output logic [COORD_W-1:0] first_x_o,
  output logic [COORD_W-1:0] first_y_o,
  output logic [COORD_W-1:0] second_x_o,
  output logic [COORD_W-1:0] second_y_o,
  output logic               degenerate_o,
  output logic               saturated_o
);

  localparam int SIDE2_LEN = ROOT_W + MUL_LAT;
  localparam int TOTAL_LAT = 9 + 2 * MUL_LAT + ROOT_W + QUO_W;
  localparam logic signed [FIN_W-1:0] COORD_MAX = (FIN_W'(1) << (COORD_W-1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0] COORD_MIN = -(FIN_W'(1) << (COORD_W-1));

  // flags and centre carried to the output stage
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               degen;
    logic               dneg;
    logic               dzero;
  } flag_t;

  typedef struct packed {
    logic [PROD_W-1:0]  xprod;
    logic [LEN_W-1:0]   len;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } side1_t;

  typedef struct packed {
    logic [PROD_W-1:0] xprod;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    flag_t             fl;
  } side2_t;

  typedef struct packed {
    logic [NLANE-1:0] qneg;
    flag_t            fl;
  } side3_t;

  function automatic logic [DIFF_W-1:0] sub_ext(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    return DIFF_W'($signed(a)) - DIFF_W'($signed(b));
  endfunction

  // returns {clamped, value}
  function automatic logic [COORD_W:0] clamp(input logic signed [FIN_W-1:0] v);
    logic [COORD_W:0] r;
    priority if (v > COORD_MAX) begin
      r = {1'b1, COORD_MAX[COORD_W-1:0]};
    end else if (v < COORD_MIN) begin
      r = {1'b1, COORD_MIN[COORD_W-1:0]};
    end else begin
      r = {1'b0, v[COORD_W-1:0]};
    end
    return r;
  endfunction

  assign busy_o = 1'b0;

  // ---------------- stage A: centre-relative differences
  logic                     va_q;
  logic [DIFF_W-1:0]        ax_q, ay_q, bx_q, by_q, dx_a_q, dy_a_q;
  logic [COORD_W-1:0]       cx_a_q, cy_a_q;
  logic [RAD_W-1:0]         rad_a_q;

  always_ff @(posedge clk_i) begin
    ax_q    <= sub_ext(line_start_x_i, center_x_i);
    ay_q    <= sub_ext(line_start_y_i, center_y_i);
    bx_q    <= sub_ext(line_end_x_i, center_x_i);
    by_q    <= sub_ext(line_end_y_i, center_y_i);
    dx_a_q  <= sub_ext(line_end_x_i, line_start_x_i);
    dy_a_q  <= sub_ext(line_end_y_i, line_start_y_i);
    cx_a_q  <= center_x_i;
    cy_a_q  <= center_y_i;
    rad_a_q <= radius_i;
  end

  // ---------------- stage B: narrow products
  logic                     vb_q;
  logic signed [PROD_W-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [R2_W-1:0]          r2_b_q;
  logic [DIFF_W-1:0]        dx_b_q, dy_b_q;
  logic [COORD_W-1:0]       cx_b_q, cy_b_q;

  always_ff @(posedge clk_i) begin
    p1_q   <= PROD_W'($signed(ax_q)) * PROD_W'($signed(by_q));
    p2_q   <= PROD_W'($signed(bx_q)) * PROD_W'($signed(ay_q));
    p3_q   <= PROD_W'($signed(dx_a_q)) * PROD_W'($signed(dx_a_q));
    p4_q   <= PROD_W'($signed(dy_a_q)) * PROD_W'($signed(dy_a_q));
    r2_b_q <= R2_W'(rad_a_q) * R2_W'(rad_a_q);
    dx_b_q <= dx_a_q;
    dy_b_q <= dy_a_q;
    cx_b_q <= cx_a_q;
    cy_b_q <= cy_a_q;
  end

  // ---------------- stage C: cross product and squared length
  logic                     vc_q;
  logic signed [PROD_W-1:0] cross_c_q;
  logic [LEN_W-1:0]         len_c_q;
  logic [R2_W-1:0]          r2_c_q;
  logic [DIFF_W-1:0]        dx_c_q, dy_c_q;
  logic [COORD_W-1:0]       cx_c_q, cy_c_q;
  logic [PROD_W-1:0]        cross_abs_c;
  logic [MULP_W-1:0]        rl_p, cc_p;

  always_ff @(posedge clk_i) begin
    cross_c_q <= p1_q - p2_q;
    len_c_q   <= LEN_W'(p3_q + p4_q);
    r2_c_q    <= r2_b_q;
    dx_c_q    <= dx_b_q;
    dy_c_q    <= dy_b_q;
    cx_c_q    <= cx_b_q;
    cy_c_q    <= cy_b_q;
  end

  assign cross_abs_c = cross_c_q[PROD_W-1] ? PROD_W'(-cross_c_q) : PROD_W'(cross_c_q);

  lci_mul u_mul_rl (
    .clk_i (clk_i),
    .a_i   (MUL_W'(r2_c_q)),
    .b_i   (MUL_W'(len_c_q)),
    .p_o   (rl_p)
  );

  lci_mul u_mul_cc (
    .clk_i (clk_i),
    .a_i   (MUL_W'(cross_abs_c)),
    .b_i   (MUL_W'(cross_abs_c)),
    .p_o   (cc_p)
  );

  // hold the other operands alongside the multipliers
  side1_t s1_q [MUL_LAT];
  logic   v1_q [MUL_LAT];

  always_ff @(posedge clk_i) begin
    s1_q[0] <= '{xprod: cross_c_q, len: len_c_q, dx: dx_c_q, dy: dy_c_q,
                 cx: cx_c_q, cy: cy_c_q};
    for (int i = 1; i < MUL_LAT; i++) begin
      s1_q[i] <= s1_q[i-1];
    end
  end

  // ---------------- stage D: discriminant and its sign
  logic   vd_q;
  sqrt_t  d_sq_q;
  side2_t d_side_q;
  side1_t s1e;

  assign s1e = s1_q[MUL_LAT-1];

  always_ff @(posedge clk_i) begin
    d_sq_q.rad         <= DISC_W'(rl_p - cc_p);
    d_sq_q.root        <= '0;
    d_sq_q.rem         <= '0;
    d_side_q.xprod     <= s1e.xprod;
    d_side_q.dx        <= s1e.dx;
    d_side_q.dy        <= s1e.dy;
    d_side_q.fl.cx     <= s1e.cx;
    d_side_q.fl.cy     <= s1e.cy;
    d_side_q.fl.degen  <= (s1e.len == '0);
    d_side_q.fl.dneg   <= (cc_p > rl_p);
    d_side_q.fl.dzero  <= (cc_p == rl_p);
  end

  // the divider needs the length beyond the root chain: carry it separately
  logic [LEN_W-1:0] len_dl_q [SIDE2_LEN + 3];

  always_ff @(posedge clk_i) begin
    len_dl_q[0] <= s1e.len;
    for (int i = 1; i < SIDE2_LEN + 3; i++) begin
      len_dl_q[i] <= len_dl_q[i-1];
    end
  end

  // ---------------- square root row: one root bit per cell
  sqrt_t  sq [ROOT_W+1];
  side2_t dl_q [SIDE2_LEN];
  logic   vdl_q [SIDE2_LEN];

  assign sq[0] = d_sq_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    lci_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .cell_i (sq[k]),
      .cell_o (sq[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= d_side_q;
    for (int i = 1; i < SIDE2_LEN; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  // ---------------- stage E: products with the root
  side2_t            e_side;
  logic [PROD_W-1:0] e_cross_abs;
  logic [DIFF_W-1:0] e_dx_abs, e_dy_abs;
  logic [MULP_W-1:0] m_cdy, m_cdx, m_dxt, m_dyt;

  assign e_side      = dl_q[ROOT_W-1];
  assign e_cross_abs = e_side.xprod[PROD_W-1] ? PROD_W'(-$signed(e_side.xprod)) : e_side.xprod;
  assign e_dx_abs    = e_side.dx[DIFF_W-1] ? DIFF_W'(-$signed(e_side.dx)) : e_side.dx;
  assign e_dy_abs    = e_side.dy[DIFF_W-1] ? DIFF_W'(-$signed(e_side.dy)) : e_side.dy;

  lci_mul u_mul_cdy (
    .clk_i (clk_i),
    .a_i   (MUL_W'(e_cross_abs)),
    .b_i   (MUL_W'(e_dy_abs)),
    .p_o   (m_cdy)
  );

  lci_mul u_mul_cdx (
    .clk_i (clk_i),
    .a_i   (MUL_W'(e_cross_abs)),
    .b_i   (MUL_W'(e_dx_abs)),
    .p_o   (m_cdx)
  );

  lci_mul u_mul_dxt (
    .clk_i (clk_i),
    .a_i   (MUL_W'(e_dx_abs)),
    .b_i   (MUL_W'(sq[ROOT_W].root)),
    .p_o   (m_dxt)
  );

  lci_mul u_mul_dyt (
    .clk_i (clk_i),
    .a_i   (MUL_W'(e_dy_abs)),
    .b_i   (MUL_W'(sq[ROOT_W].root)),
    .p_o   (m_dyt)
  );

  // ---------------- stage F: signed terms
  side2_t                  f_in;
  logic                    vf_q;
  logic signed [NUM_W-1:0] bx_t_q, rx_t_q, by_t_q, ry_t_q;
  flag_t                   fl_f_q;
  logic                    sc, sx, sy;

  assign f_in = dl_q[SIDE2_LEN-1];
  assign sc   = f_in.xprod[PROD_W-1];
  assign sx   = f_in.dx[DIFF_W-1];
  assign sy   = f_in.dy[DIFF_W-1];

  always_ff @(posedge clk_i) begin
    bx_t_q <= (sc ^ sy) ? -$signed(NUM_W'(m_cdy)) : $signed(NUM_W'(m_cdy));
    rx_t_q <= (sx ^ sy) ? -$signed(NUM_W'(m_dxt)) : $signed(NUM_W'(m_dxt));
    by_t_q <= (sc ^ sx) ? $signed(NUM_W'(m_cdx)) : -$signed(NUM_W'(m_cdx));
    ry_t_q <= $signed(NUM_W'(m_dyt));
    fl_f_q <= f_in.fl;
  end

  // ---------------- stage G: numerators, plus root then minus root
  logic                    vg_q;
  logic signed [NUM_W-1:0] num_q [NLANE];
  flag_t                   fl_g_q;

  always_ff @(posedge clk_i) begin
    num_q[0] <= bx_t_q + rx_t_q;
    num_q[1] <= by_t_q + ry_t_q;
    num_q[2] <= bx_t_q - rx_t_q;
    num_q[3] <= by_t_q - ry_t_q;
    fl_g_q   <= fl_f_q;
  end

  // ---------------- stage H: magnitudes into the divider rows
  logic   vh_q;
  div_t   h_div_q [NLANE];
  side3_t h_side_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLANE; l++) begin
      logic [NUM_W-1:0] mag;
      mag = num_q[l][NUM_W-1] ? NUM_W'(-num_q[l]) : NUM_W'(num_q[l]);
      h_div_q[l].den     <= len_dl_q[SIDE2_LEN + 2];
      h_div_q[l].rem     <= LEN_W'(mag >> QUO_W);
      h_div_q[l].nq      <= mag[QUO_W-1:0];
      h_side_q.qneg[l]   <= num_q[l][NUM_W-1];
    end
    h_side_q.fl <= fl_g_q;
  end

  // ---------------- divider rows: one quotient bit per cell and lane
  div_t   dch [NLANE][QUO_W+1];
  side3_t s3_q [QUO_W];
  logic   v3_q [QUO_W];

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    assign dch[l][0] = h_div_q[l];
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
      lci_div_cell u_cell (
        .clk_i  (clk_i),
        .cell_i (dch[l][k]),
        .cell_o (dch[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q[0] <= h_side_q;
    for (int i = 1; i < QUO_W; i++) begin
      s3_q[i] <= s3_q[i-1];
    end
  end

  // ---------------- stage I: round to nearest, ties away from zero
  logic             vi_q;
  logic [QUO_W:0]   q_i_q [NLANE];
  side3_t           i_side_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLANE; l++) begin
      q_i_q[l] <= (QUO_W+1)'(dch[l][QUO_W].nq)
                + (QUO_W+1)'({dch[l][QUO_W].rem, 1'b0} >= {1'b0, dch[l][QUO_W].den});
    end
    i_side_q <= s3_q[QUO_W-1];
  end

  // ---------------- stage J: sign, centre, clamp and select
  logic [COORD_W:0] cl [NLANE];
  logic             valid_q, degen_q, sat_q;
  logic [1:0]       hit_q;
  logic [COORD_W-1:0] fx_q, fy_q, sx_q, sy_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic signed [FIN_W-1:0] qs, cen;
      qs  = i_side_q.qneg[l] ? -$signed(FIN_W'(q_i_q[l])) : $signed(FIN_W'(q_i_q[l]));
      cen = (l % 2 == 0) ? FIN_W'($signed(i_side_q.fl.cx)) : FIN_W'($signed(i_side_q.fl.cy));
      cl[l] = clamp(qs + cen);
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (i_side_q.fl.degen) begin
      hit_q <= HIT_NONE; degen_q <= 1'b1; sat_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; sx_q <= '0; sy_q <= '0;
    end else if (i_side_q.fl.dneg) begin
      hit_q <= HIT_NONE; degen_q <= 1'b0; sat_q <= 1'b0;
      fx_q <= '0; fy_q <= '0; sx_q <= '0; sy_q <= '0;
    end else if (i_side_q.fl.dzero) begin
      hit_q <= HIT_ONE; degen_q <= 1'b0;
      sat_q <= cl[0][COORD_W] | cl[1][COORD_W];
      fx_q <= cl[0][COORD_W-1:0]; fy_q <= cl[1][COORD_W-1:0];
      sx_q <= '0; sy_q <= '0;
    end else begin
      hit_q <= HIT_TWO; degen_q <= 1'b0;
      sat_q <= cl[0][COORD_W] | cl[1][COORD_W] | cl[2][COORD_W] | cl[3][COORD_W];
      fx_q <= cl[0][COORD_W-1:0]; fy_q <= cl[1][COORD_W-1:0];
      sx_q <= cl[2][COORD_W-1:0]; sy_q <= cl[3][COORD_W-1:0];
    end
  end

  // ---------------- valid bits: advance every cycle, clear on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0;
      vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0; vi_q <= 1'b0;
      valid_q <= 1'b0;
      for (int i = 0; i < MUL_LAT; i++) v1_q[i] <= 1'b0;
      for (int i = 0; i < SIDE2_LEN; i++) vdl_q[i] <= 1'b0;
      for (int i = 0; i < QUO_W; i++) v3_q[i] <= 1'b0;
    end else begin
      va_q    <= start_i & ~busy_o;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      v1_q[0] <= vc_q;
      for (int i = 1; i < MUL_LAT; i++) v1_q[i] <= v1_q[i-1];
      vd_q     <= v1_q[MUL_LAT-1];
      vdl_q[0] <= vd_q;
      for (int i = 1; i < SIDE2_LEN; i++) vdl_q[i] <= vdl_q[i-1];
      vf_q    <= vdl_q[SIDE2_LEN-1];
      vg_q    <= vf_q;
      vh_q    <= vg_q;
      v3_q[0] <= vh_q;
      for (int i = 1; i < QUO_W; i++) v3_q[i] <= v3_q[i-1];
      vi_q    <= v3_q[QUO_W-1];
      valid_q <= vi_q;
    end
  end

  assign valid_o      = valid_q;
  assign hit_count_o  = hit_q;
  assign first_x_o    = fx_q;
  assign first_y_o    = fy_q;
  assign second_x_o   = sx_q;
  assign second_y_o   = sy_q;
  assign degenerate_o = degen_q;
  assign saturated_o  = sat_q;

  // ---------------- checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##TOTAL_LAT valid_o)
    else $error("result did not appear after the pipeline latency");

  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hit_count_o == HIT_NONE || hit_count_o == HIT_ONE || hit_count_o == HIT_TWO))
    else $error("hit count out of range");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> hit_count_o == HIT_NONE && !saturated_o)
    else $error("degenerate line reported a hit");

  a_tangent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && hit_count_o != HIT_TWO |-> second_x_o == '0 && second_y_o == '0)
    else $error("second point set without two hits");

endmodule
`default_nettype wire

>>> tb/sv/line_circle_intersection_top_tb.sv
// Self-checking testbench for the pipelined line/circle intersection block.
`default_nettype none
module line_circle_intersection_top_tb import lci_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Wide signed word for the exact integer arithmetic of the predictor
  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [COORD_W-1:0] sx, sy, ex, ey, cx, cy;
    logic [RAD_W-1:0]          r;
  } query_t;

  typedef struct {
    logic [1:0]                hits;
    logic signed [COORD_W-1:0] fx, fy, sx, sy;
    logic                      degen;
    logic                      sat;
  } crossing_t;

  localparam int  CYCLE_LIMIT = 50000;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  CMAX        = (1 <<< (COORD_W - 1)) - 1;
  localparam int  CMIN        = -CMAX - 1;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [COORD_W-1:0] line_start_x_i, line_start_y_i, line_end_x_i, line_end_y_i;
  logic [COORD_W-1:0] center_x_i, center_y_i;
  logic [RAD_W-1:0]   radius_i;
  logic               valid_o;
  logic [1:0]         hit_count_o;
  logic [COORD_W-1:0] first_x_o, first_y_o, second_x_o, second_y_o;
  logic               degenerate_o, saturated_o;

  crossing_t pending_hits[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        gaps_on;

  line_circle_intersection_top u_top (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .line_start_x_i, .line_start_y_i, .line_end_x_i, .line_end_y_i,
    .center_x_i, .center_y_i, .radius_i,
    .valid_o, .hit_count_o, .first_x_o, .first_y_o, .second_x_o, .second_y_o,
    .degenerate_o, .saturated_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Floor square root of a non-negative value, one root bit per step
  function automatic wide_t int_sqrt(wide_t n);
    logic [159:0] rest, root, probe;
    rest  = n;
    root  = '0;
    probe = 160'd1 << 158;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return wide_t'(root);
  endfunction

  // (base +/- root) / len2, rounded half away from zero, then offset by the
  // centre and clamped to the coordinate range
  function automatic logic signed [COORD_W-1:0] place_coord(
      wide_t base, wide_t root, bit plus, wide_t len2, wide_t centre, inout logic sat);
    wide_t num, mag, quo, rem, sum;
    num = plus ? base + root : base - root;
    mag = (num < 0) ? -num : num;
    quo = mag / len2;
    rem = mag % len2;
    if (2 * rem >= len2) quo = quo + 1;
    if (num < 0) quo = -quo;
    sum = quo + centre;
    if (sum > CMAX) begin
      sum = wide_t'(CMAX);
      sat = 1'b1;
    end
    if (sum < CMIN) begin
      sum = wide_t'(CMIN);
      sat = 1'b1;
    end
    return sum[COORD_W-1:0];
  endfunction

  function automatic crossing_t solve_query(query_t q);
    wide_t sx, sy, ex, ey, cx, cy, rad;
    wide_t ax, ay, bx, by, dx, dy, xprod, len2, disc, root, bxt, rxt, byt, ryt;
    crossing_t h;
    h = '{hits: HIT_NONE, fx: '0, fy: '0, sx: '0, sy: '0, degen: 1'b0, sat: 1'b0};
    sx = wide_t'(q.sx); sy = wide_t'(q.sy); ex = wide_t'(q.ex); ey = wide_t'(q.ey);
    cx = wide_t'(q.cx); cy = wide_t'(q.cy);
    rad = wide_t'({1'b0, q.r});
    ax = sx - cx; ay = sy - cy;
    bx = ex - cx; by = ey - cy;
    dx = ex - sx; dy = ey - sy;
    xprod = ax * by - bx * ay;
    len2  = dx * dx + dy * dy;
    if (len2 == 0) begin
      h.degen = 1'b1;
      return h;
    end
    disc = rad * rad * len2 - xprod * xprod;
    if (disc < 0) return h;
    root = int_sqrt(disc);
    bxt  = xprod * dy;
    rxt  = ((dy < 0) ? -dx : dx) * root;
    byt  = -(xprod * dx);
    ryt  = ((dy < 0) ? -dy : dy) * root;
    h.fx = place_coord(bxt, rxt, 1'b1, len2, cx, h.sat);
    h.fy = place_coord(byt, ryt, 1'b1, len2, cy, h.sat);
    if (disc == 0) begin
      h.hits = HIT_ONE;
    end else begin
      h.hits = HIT_TWO;
      h.sx = place_coord(bxt, rxt, 1'b0, len2, cx, h.sat);
      h.sy = place_coord(byt, ryt, 1'b0, len2, cy, h.sat);
    end
    return h;
  endfunction

  // Present one query, hold it until taken, then maybe idle for a burst
  task automatic send_query(query_t q);
    line_start_x_i <= q.sx;
    line_start_y_i <= q.sy;
    line_end_x_i   <= q.ex;
    line_end_y_i   <= q.ey;
    center_x_i     <= q.cx;
    center_y_i     <= q.cy;
    radius_i       <= q.r;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_hits.insert(pending_hits.size(), solve_query(q));
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    query_t q;
    q.sx = COORD_W'(sx); q.sy = COORD_W'(sy); q.ex = COORD_W'(ex); q.ey = COORD_W'(ey);
    q.cx = COORD_W'(cx); q.cy = COORD_W'(cy); q.r = RAD_W'(r);
    send_query(q);
  endtask

  // Any bit pattern on every field
  function automatic query_t noise_query();
    query_t q;
    q.sx = COORD_W'($urandom); q.sy = COORD_W'($urandom);
    q.ex = COORD_W'($urandom); q.ey = COORD_W'($urandom);
    q.cx = COORD_W'($urandom); q.cy = COORD_W'($urandom); q.r = RAD_W'($urandom);
    return q;
  endfunction

  // Line placed near a circle so that misses, crossings and near-tangents mix;
  // scale picks small or large geometry
  function automatic query_t near_query();
    query_t q;
    int span, cx, cy, r;
    span = 1 << $urandom_range(4, 21);
    cx = $signed($urandom_range(0, 2 * span)) - span;
    cy = $signed($urandom_range(0, 2 * span)) - span;
    r  = $urandom_range(0, span);
    q.cx = COORD_W'(cx); q.cy = COORD_W'(cy); q.r = RAD_W'(r);
    q.sx = COORD_W'(cx + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
    q.sy = COORD_W'(cy + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
    case ($urandom_range(0, 5))
      0: begin
        q.ex = q.sx;
        q.ey = COORD_W'(cy + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
      end
      1: begin
        q.ey = q.sy;
        q.ex = COORD_W'(cx + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
      end
      2: begin
        q.ex = q.sx;
        q.ey = q.sy;
      end
      default: begin
        q.ex = COORD_W'(cx + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
        q.ey = COORD_W'(cy + $signed($urandom_range(0, 4 * r + 2)) - 2 * r - 1);
      end
    endcase
    return q;
  endfunction

  task automatic test_special_cases();
    // coinciding endpoints, zero and full-scale
    send_fields(0, 0, 0, 0, 0, 0, 256);
    send_fields(CMAX, CMIN, CMAX, CMIN, 5, -7, 'h7FFFFF);
    // clear miss
    send_fields(-256, 1024, 256, 1024, 0, 0, 256);
    // tangent lines: horizontal, vertical, with offset centre
    send_fields(-256, 256, 256, 256, 0, 0, 256);
    send_fields(256, 512, 256, -512, 0, 0, 256);
    send_fields(1000, 2256, 1500, 2256, 1000, 2000, 256);
    // two crossings, both directions of dy and dy of zero
    send_fields(-1024, 0, 1024, 0, 0, 0, 256);
    send_fields(1024, 0, -1024, 0, 0, 0, 256);
    send_fields(0, -1024, 0, 1024, 77, -33, 300);
    send_fields(0, 1024, 0, -1024, 77, -33, 300);
    send_fields(-700, -300, 500, 900, 10, 20, 600);
    send_fields(700, 300, -500, -900, 10, 20, 600);
    // zero radius through and beside the centre
    send_fields(-5, 0, 5, 0, 0, 0, 0);
    send_fields(-5, 1, 5, 1, 0, 0, 0);
    // extremes of every field, clamped results
    send_fields(CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 'h7FFFFF);
    send_fields(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, 'h7FFFFF);
    send_fields(CMAX - 10, 0, CMAX - 10, 1, CMAX - 100, 0, 'h7FFFFF);
    send_fields(CMIN, CMAX, CMAX, CMIN, 0, 0, 'h7FFFFF);
    send_fields(CMIN, 0, CMIN + 1, 0, 0, 0, 'h7FFFFF);
    send_fields(-1, -1, 0, 0, -1, -1, 1);
  endtask

  task automatic test_random_geometry(int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) send_query(noise_query());
      else send_query(near_query());
    end
  endtask

  // Compare each result with the oldest expectation at the edge ending its cycle
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && valid_o) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = pending_hits.pop_front();
        if (hit_count_o !== want.hits || first_x_o !== want.fx ||
            first_y_o !== want.fy || second_x_o !== want.sx ||
            second_y_o !== want.sy || degenerate_o !== want.degen ||
            saturated_o !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch cyc %0d: exp hits %0d (%0d,%0d) (%0d,%0d) dg %0b sat %0b",
                      " got hits %0d (%0d,%0d) (%0d,%0d) dg %0b sat %0b"},
                     cycles, want.hits, want.fx, want.fy, want.sx, want.sy,
                     want.degen, want.sat, hit_count_o, $signed(first_x_o),
                     $signed(first_y_o), $signed(second_x_o), $signed(second_y_o),
                     degenerate_o, saturated_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_circle_intersection_top test failed");
      $finish;
    end
  end

  initial begin
    int waited;
    gaps_on        = 1'b1;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    line_start_x_i = '0;
    line_start_y_i = '0;
    line_end_x_i   = '0;
    line_end_y_i   = '0;
    center_x_i     = '0;
    center_y_i     = '0;
    radius_i       = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_random_geometry(300);
    // last stretch back to back, no idling
    gaps_on = 1'b0;
    test_random_geometry(150);
    start_i <= 1'b0;

    waited = 0;
    while (pending_hits.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("line_circle_intersection_top test passed");
    end else begin
      $display("line_circle_intersection_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
src/lci_pkg.sv
src/lci_mul.sv
src/lci_sqrt_cell.sv
src/lci_div_cell.sv
src/line_circle_intersection_top.sv
tb/sv/line_circle_intersection_top_tb.sv
